// ===== hdl/bhsr_pkg.sv =====
// ============================================================================
// bhsr_pkg
// Shared types and constants for the byte histogram and sorted ranking block.
// ============================================================================
package bhsr_pkg;

    localparam int SYM_W      = 8;
    localparam int OCC_W      = 32;
    localparam int DISTINCT_W = 9;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [SYM_W-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]      symbol;
        logic [OCC_W-1:0]      occurrences;
        logic [DISTINCT_W-1:0] distinct_count;
        logic                  is_last;
        logic                  is_empty;
    } out_item_t;

    typedef struct packed {
        logic inc;
        logic rotate;
        logic clear;
    } hist_ctrl_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } sort_ctrl_t;

endpackage

// ===== hdl/bhsr_hist_cell.sv =====
// ============================================================================
// bhsr_hist_cell
// One saturating histogram counter; rotates to its neighbor during ranking.
// ============================================================================
module bhsr_hist_cell #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bhsr_pkg::hist_ctrl_t  ctrl,
    input  logic                  hit,
    input  logic [COUNT_BITS-1:0] rot_in,
    output logic [COUNT_BITS-1:0] count
);
    import bhsr_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.rotate) begin
            count_next = rot_in;
        end else if (ctrl.inc && hit && (count_reg != '1)) begin
            count_next = count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== hdl/bhsr_sort_cell.sv =====
// ============================================================================
// bhsr_sort_cell
// One slot of the insertion sorter; shifts right on insert, left on pop.
// ============================================================================
module bhsr_sort_cell #(
    parameter int COUNT_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bhsr_pkg::sort_ctrl_t       ctrl,
    input  logic [bhsr_pkg::SYM_W-1:0] new_sym,
    input  logic [COUNT_BITS-1:0]      new_count,
    input  logic                       left_keep,
    input  logic [bhsr_pkg::SYM_W-1:0] left_sym,
    input  logic [COUNT_BITS-1:0]      left_count,
    input  logic                       left_valid,
    input  logic [bhsr_pkg::SYM_W-1:0] right_sym,
    input  logic [COUNT_BITS-1:0]      right_count,
    input  logic                       right_valid,
    output logic [bhsr_pkg::SYM_W-1:0] sym,
    output logic [COUNT_BITS-1:0]      count,
    output logic                       valid,
    output logic                       keep
);
    import bhsr_pkg::*;

    logic [SYM_W-1:0]      sym_reg;
    logic [SYM_W-1:0]      sym_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  valid_reg;
    logic                  valid_next;

    // equal counts stay ahead of the newcomer, which keeps the order stable
    assign keep = valid_reg && (count_reg <= new_count);

    always_comb begin
        sym_next   = sym_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.insert && !keep) begin
            if (left_keep) begin
                sym_next   = new_sym;
                count_next = new_count;
                valid_next = 1'b1;
            end else begin
                sym_next   = left_sym;
                count_next = left_count;
                valid_next = left_valid;
            end
        end else if (ctrl.pop) begin
            sym_next   = right_sym;
            count_next = right_count;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg   <= sym_next;
        count_reg <= count_next;
    end

    assign sym   = sym_reg;
    assign count = count_reg;
    assign valid = valid_reg;

endmodule

// ===== hdl/byte_histogram_sorted_ranking.sv =====
// ============================================================================
// byte_histogram_sorted_ranking
// Byte histogram with ranked read-out by ascending count (stable on ties).
// ============================================================================
//
//  channel  | ports                         | carries
//  ---------+-------------------------------+------------------------------------
//  input    | s_valid s_ready s_payload     | cmd, byte_value (count or pull)
//  result   | m_valid m_ready m_payload     | symbol, occurrences, distinct_count,
//           |                               | is_last, is_empty (one per pull)
//
//  A data transfer is counted as it is taken; a pull on a ranked set hands
//  out the next entry. The first pull of a set ranks it: the histogram row
//  rotates past the sorter in ST_RANK, ready stays low through ST_RANK and
//  ST_EMIT, and the result is registered in ST_EMIT.
//  Reset clears every histogram counter and the sorter valid bits at once.
//  A held result blocks only the next transfer, and only until it is taken.
// ============================================================================
module byte_histogram_sorted_ranking #(
    parameter int SYMBOLS    = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhsr_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output bhsr_pkg::out_item_t m_payload
);
    import bhsr_pkg::*;

    localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [IDX_W-1:0]      rank_cnt_reg;
    logic [IDX_W-1:0]      rank_cnt_next;
    logic [DISTINCT_W-1:0] total_reg;
    logic [DISTINCT_W-1:0] total_next;
    logic                  ranked_valid_reg;
    logic                  ranked_valid_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_item_t             m_payload_reg;
    out_item_t             m_payload_next;

    hist_ctrl_t hist_ctrl;
    sort_ctrl_t sort_ctrl;

    logic [COUNT_BITS-1:0] hist_count [SYMBOLS];
    logic [SYM_W-1:0]      sort_sym   [SYMBOLS];
    logic [COUNT_BITS-1:0] sort_count [SYMBOLS];
    logic                  sort_valid [SYMBOLS];
    logic                  sort_keep  [SYMBOLS];

    logic                  s_fire;
    logic                  data_fire;
    logic                  pull_fire;
    logic                  emit;
    logic                  head_last;
    logic [SYM_W-1:0]      feed_sym;
    logic [COUNT_BITS-1:0] feed_count;

    // accept while idle and the result register is free or draining now
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign data_fire = s_fire && (s_payload.cmd == CMD_DATA);
    assign pull_fire = s_fire && (s_payload.cmd == CMD_PULL);

    // head of the histogram row carries symbol rank_cnt_reg while ranking
    assign feed_sym   = SYM_W'(rank_cnt_reg);
    assign feed_count = hist_count[0];

    assign head_last = !sort_valid[1];

    // hand out one ranked entry: a pull on a live ranking, or the end of ranking
    assign emit = (pull_fire && ranked_valid_reg) || (state_reg == ST_EMIT);

    always_comb begin
        state_next        = state_reg;
        rank_cnt_next     = rank_cnt_reg;
        total_next        = total_reg;
        ranked_valid_next = ranked_valid_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_payload_next    = m_payload_reg;
        hist_ctrl         = '0;
        sort_ctrl         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (data_fire) begin
                    // count the byte; drop any ranking in progress
                    hist_ctrl.inc     = 1'b1;
                    ranked_valid_next = 1'b0;
                end else if (pull_fire && !ranked_valid_reg) begin
                    // start ranking from an empty sorter
                    sort_ctrl.clear = 1'b1;
                    rank_cnt_next   = '0;
                    total_next      = '0;
                    state_next      = ST_RANK;
                end
            end
            ST_RANK: begin
                hist_ctrl.rotate = 1'b1;
                if (feed_count != '0) begin
                    sort_ctrl.insert = 1'b1;
                    total_next       = total_reg + {{(DISTINCT_W-1){1'b0}}, 1'b1};
                end
                rank_cnt_next = rank_cnt_reg + {{(IDX_W-1){1'b0}}, 1'b1};
                if (rank_cnt_reg == IDX_W'(SYMBOLS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                state_next        = ST_IDLE;
                ranked_valid_next = (total_reg != '0);
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
            if (total_reg == '0) begin
                // nothing counted: report empty, state stays cleared
                m_payload_next          = '0;
                m_payload_next.is_empty = 1'b1;
            end else begin
                m_payload_next.symbol         = sort_sym[0];
                m_payload_next.occurrences    = OCC_W'(sort_count[0]);
                m_payload_next.distinct_count = total_reg;
                m_payload_next.is_last        = head_last;
                m_payload_next.is_empty       = 1'b0;
                if (head_last) begin
                    // set finished: clear for the next one
                    hist_ctrl.clear   = 1'b1;
                    sort_ctrl.clear   = 1'b1;
                    ranked_valid_next = 1'b0;
                    total_next        = '0;
                end else begin
                    sort_ctrl.pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            rank_cnt_reg     <= '0;
            total_reg        <= '0;
            ranked_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            rank_cnt_reg     <= rank_cnt_next;
            total_reg        <= total_next;
            ranked_valid_reg <= ranked_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // histogram row: cell i holds symbol i at rest, rotates toward cell 0
    for (genvar i = 0; i < SYMBOLS; i++) begin : g_hist
        bhsr_hist_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (hist_ctrl),
            .hit     (s_payload.byte_value == SYM_W'(i)),
            .rot_in  (hist_count[(i + 1) % SYMBOLS]),
            .count   (hist_count[i])
        );
    end

    // sorter row: ascending counts from cell 0
    for (genvar i = 0; i < SYMBOLS; i++) begin : g_sort
        logic                  left_keep;
        logic [SYM_W-1:0]      left_sym;
        logic [COUNT_BITS-1:0] left_count;
        logic                  left_valid;
        logic [SYM_W-1:0]      right_sym;
        logic [COUNT_BITS-1:0] right_count;
        logic                  right_valid;

        if (i == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_sym   = feed_sym;
            assign left_count = feed_count;
            assign left_valid = 1'b1;
        end else begin : g_inner_left
            assign left_keep  = sort_keep[i-1];
            assign left_sym   = sort_sym[i-1];
            assign left_count = sort_count[i-1];
            assign left_valid = sort_valid[i-1];
        end

        if (i == SYMBOLS - 1) begin : g_final
            assign right_sym   = feed_sym;
            assign right_count = feed_count;
            assign right_valid = 1'b0;
        end else begin : g_inner_right
            assign right_sym   = sort_sym[i+1];
            assign right_count = sort_count[i+1];
            assign right_valid = sort_valid[i+1];
        end

        bhsr_sort_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (sort_ctrl),
            .new_sym     (feed_sym),
            .new_count   (feed_count),
            .left_keep   (left_keep),
            .left_sym    (left_sym),
            .left_count  (left_count),
            .left_valid  (left_valid),
            .right_sym   (right_sym),
            .right_count (right_count),
            .right_valid (right_valid),
            .sym         (sort_sym[i]),
            .count       (sort_count[i]),
            .valid       (sort_valid[i]),
            .keep        (sort_keep[i])
        );
    end

endmodule
